@@ hw/rtl/stga_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stga_pkg
// Shared constants, codes, types and the log fraction table of the split test
// gain accumulator.
// ----------------------------------------------------------------------------
package stga_pkg;

    // Default values of the top-level parameters.
    localparam int CLASSES_DEF      = 16;
    localparam int MAX_FEATURES_DEF = 4;

    // Fixed field widths.
    localparam int FEAT_W   = 16;
    localparam int WGT_W    = 16;
    localparam int THR_W    = 34;
    localparam int FCNT_W   = 3;
    localparam int LABEL_W  = 4;
    localparam int SW_W     = 16;
    localparam int TOT_W    = 32;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 34;

    // Entropy arithmetic widths.
    localparam int P_W      = 17;
    localparam int LEN_W    = 17;
    localparam int ENT_W    = 24;
    localparam int DEN_W    = 33;
    localparam int NUM_W    = 57;
    localparam int QUO_W    = 24;

    // Operation codes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_SCORE  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ZERO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_ONE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_TWO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_THREE  = 3'd5;

    // Control from the sequencer to the histogram store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_true;
        logic clear;
    } hist_ctrl_t;

    // round(4096 * log2(1 + k/64)).
    localparam logic [11:0] LOG_FRAC [64] = '{
        12'd0,    12'd92,   12'd182,  12'd271,  12'd358,  12'd445,  12'd530,  12'd613,
        12'd696,  12'd778,  12'd858,  12'd937,  12'd1016, 12'd1093, 12'd1169, 12'd1244,
        12'd1319, 12'd1392, 12'd1465, 12'd1536, 12'd1607, 12'd1677, 12'd1746, 12'd1814,
        12'd1882, 12'd1949, 12'd2015, 12'd2080, 12'd2145, 12'd2208, 12'd2272, 12'd2334,
        12'd2396, 12'd2457, 12'd2518, 12'd2578, 12'd2637, 12'd2696, 12'd2754, 12'd2812,
        12'd2869, 12'd2926, 12'd2982, 12'd3037, 12'd3092, 12'd3146, 12'd3200, 12'd3254,
        12'd3307, 12'd3359, 12'd3412, 12'd3463, 12'd3514, 12'd3565, 12'd3615, 12'd3665,
        12'd3715, 12'd3764, 12'd3812, 12'd3861, 12'd3908, 12'd3956, 12'd4003, 12'd4050
    };

endpackage
`default_nettype wire

@@ hw/rtl/stga_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stga_divider
// Restoring divider, one quotient bit per cycle. The upper part of the
// dividend must be below the divisor, so that the quotient fits its width.
// ----------------------------------------------------------------------------
module stga_divider
    import stga_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  busy,
    output logic [QUO_W-1:0]      quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] low_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {rem_reg, low_reg[QUO_W-1]};
        fits  = trial >= {1'b0, den_reg};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:QUO_W];
            low_reg <= num[QUO_W-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            low_reg <= {low_reg[QUO_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = low_reg;

endmodule
`default_nettype wire

@@ hw/rtl/stga_hist_mem.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stga_hist_mem
// True-side and false-side class histograms in two synchronous memories with
// a registered read. Per-entry valid bits make unwritten or cleared bins read
// as zero.
// ----------------------------------------------------------------------------
module stga_hist_mem
    import stga_pkg::*;
#(
    parameter int CLASSES = CLASSES_DEF,
    parameter int ADDR_W  = $clog2(CLASSES)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hist_ctrl_t        ctrl,
    input  wire logic [ADDR_W-1:0] rd_addr,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [TOT_W-1:0]  wr_data,
    output logic [TOT_W-1:0]       rd_true,
    output logic [TOT_W-1:0]       rd_false
);

    logic [TOT_W-1:0]   mem_true  [CLASSES];
    logic [TOT_W-1:0]   mem_false [CLASSES];
    logic [CLASSES-1:0] vld_true_reg;
    logic [CLASSES-1:0] vld_false_reg;
    logic [TOT_W-1:0]   data_true_reg;
    logic [TOT_W-1:0]   data_false_reg;
    logic               ok_true_reg;
    logic               ok_false_reg;

    // Memory arrays: one write port each, registered read.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && ctrl.wr_true)
        begin
            mem_true[wr_addr] <= wr_data;
        end
        if (ctrl.wr_en && !ctrl.wr_true)
        begin
            mem_false[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            data_true_reg  <= mem_true[rd_addr];
            data_false_reg <= mem_false[rd_addr];
        end
    end

    // Valid bits, cleared at once by reset or a clear operation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_true_reg  <= '0;
            vld_false_reg <= '0;
            ok_true_reg   <= 1'b0;
            ok_false_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                vld_true_reg  <= '0;
                vld_false_reg <= '0;
            end
            else if (ctrl.wr_en)
            begin
                if (ctrl.wr_true)
                begin
                    vld_true_reg[wr_addr] <= 1'b1;
                end
                else
                begin
                    vld_false_reg[wr_addr] <= 1'b1;
                end
            end
            if (ctrl.rd_en)
            begin
                ok_true_reg  <= vld_true_reg[rd_addr];
                ok_false_reg <= vld_false_reg[rd_addr];
            end
        end
    end

    assign rd_true  = ok_true_reg  ? data_true_reg  : '0;
    assign rd_false = ok_false_reg ? data_false_reg : '0;

endmodule
`default_nettype wire

@@ hw/rtl/split_test_gain_accumulator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// split_test_gain_accumulator_core
// Candidate split test: class histograms per side, updated by samples and
// scored by information gain.
// ----------------------------------------------------------------------------
// Items enter on in_valid/in_ready and each gives exactly one result item on
// out_valid/out_ready. Configuration must be written through cfg_wr_en,
// cfg_index and cfg_data only while the block is idle; the block does not enforce it.
// One item is worked on at a time; in_ready is high only while idle.
// Clear and unused operations go from idle straight to S_OUT and the result register.
// Update: the bin of the label is read as the item is taken, then one shared
// multiplier forms the projection a feature a cycle, and the bin is then
// modified and written back.
// Score: each class needs one memory read and three entropy terms, each one
// serial division unless its count or total is zero, then the weighted
// posterior needs one more division; with both totals zero the gain is zero.
// The result register parts the two sides: the next item is accepted while
// a result waits, and work stalls only when a new result is ready and the
// receiver still holds off out_ready.
// Reset clears the histograms (valid bits), the totals, the configuration and
// the control registers to their reset values at once.
// ----------------------------------------------------------------------------
module split_test_gain_accumulator_core
    import stga_pkg::*;
#(
    parameter int CLASSES      = CLASSES_DEF,
    parameter int MAX_FEATURES = MAX_FEATURES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire logic [FEAT_W-1:0]    feature_a,
    input  wire logic [FEAT_W-1:0]    feature_b,
    input  wire logic [FEAT_W-1:0]    feature_c,
    input  wire logic [FEAT_W-1:0]    feature_d,
    input  wire logic [LABEL_W-1:0]   class_label,
    input  wire logic [SW_W-1:0]      sample_weight,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      went_true,
    output logic [GAIN_W-1:0]         gain,
    output logic [TOT_W-1:0]          true_weight_total,
    output logic [TOT_W-1:0]          false_weight_total
);

    localparam int ADDR_W = $clog2(CLASSES);
    localparam int WIDE_W = ADDR_W + LABEL_W;
    localparam int FI_W   = 3;

    typedef enum logic [3:0] {
        S_IDLE, S_PROJ, S_UPD, S_SRD, S_TERM, S_DIV, S_LOG, S_MUL, S_ACC,
        S_POST1, S_POST2, S_PDIVS, S_PDIV, S_GAIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        TK_PRIOR, TK_TRUE, TK_FALSE
    } term_t;

    state_t state_reg;
    term_t  term_reg;

    // Configuration registers.
    logic signed [THR_W-1:0] threshold_reg;
    logic [FCNT_W-1:0]       fcount_reg;
    logic signed [WGT_W-1:0] weight_reg [4];

    // Captured item.
    logic signed [FEAT_W-1:0] feat_reg [4];
    logic [LABEL_W-1:0]       label_reg;
    logic [SW_W-1:0]          sw_reg;

    // Working state.
    logic signed [THR_W-1:0] proj_reg;
    logic [FI_W-1:0]         fidx_reg;
    logic [TOT_W-1:0]        ttot_reg;
    logic [TOT_W-1:0]        ftot_reg;
    logic [ADDR_W-1:0]       cls_reg;
    logic [ENT_W-1:0]        prior_reg;
    logic [ENT_W-1:0]        ht_reg;
    logic [ENT_W-1:0]        hf_reg;
    logic [P_W-1:0]          p_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [ENT_W-1:0]        term_val_reg;
    logic [NUM_W-1:0]        prod_reg;
    logic [NUM_W-1:0]        sum_reg;
    logic                    res_went_reg;
    logic [GAIN_W-1:0]       res_gain_reg;

    // Output registers.
    logic              out_valid_reg;
    logic              went_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [TOT_W-1:0]  otrue_reg;
    logic [TOT_W-1:0]  ofalse_reg;

    // Histogram store and divider connections.
    hist_ctrl_t        hctrl;
    logic [ADDR_W-1:0] hrd_addr;
    logic [ADDR_W-1:0] label_addr;
    logic [TOT_W-1:0]  hwr_data;
    logic [TOT_W-1:0]  bin_true;
    logic [TOT_W-1:0]  bin_false;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_busy;
    logic [QUO_W-1:0]  div_quot;

    // Combinational helpers.
    logic [WIDE_W-1:0]       label_wide;
    logic [WIDE_W-1:0]       label_in_wide;
    logic                    label_ok;
    logic [FI_W-1:0]         used;
    logic signed [2*FEAT_W-1:0] fprod;
    logic                    went;
    logic [TOT_W-1:0]        bin_sel;
    logic [TOT_W:0]          bin_sum;
    logic [TOT_W:0]          tot_sum;
    logic [TOT_W-1:0]        bin_new;
    logic [TOT_W-1:0]        tot_new;
    logic [DEN_W-1:0]        n_all;
    logic [DEN_W-1:0]        cnt_sel;
    logic [DEN_W-1:0]        tot_sel;
    logic [4:0]              lead;
    logic [P_W+5:0]          kshift;
    logic [5:0]              kidx;
    logic [LEN_W-1:0]        len_calc;
    logic [P_W+LEN_W-1:0]    plen;
    logic [P_W-1:0]          p_clamp;
    logic [ENT_W:0]          gain_diff;
    logic                    last_cls;
    logic [TOT_W+ENT_W-1:0]  prod_true;
    logic [TOT_W+ENT_W-1:0]  prod_false;

    stga_hist_mem #(
        .CLASSES (CLASSES),
        .ADDR_W  (ADDR_W)
    ) u_hist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (hctrl),
        .rd_addr  (hrd_addr),
        .wr_addr  (label_addr),
        .wr_data  (hwr_data),
        .rd_true  (bin_true),
        .rd_false (bin_false)
    );

    stga_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // Label range check and bin address.
    always_comb
    begin
        label_wide    = {ADDR_W'(0), label_reg};
        label_in_wide = {ADDR_W'(0), class_label};
        label_ok      = label_wide < WIDE_W'(CLASSES);
        label_addr    = label_wide[ADDR_W-1:0];
        used       = (fcount_reg > FCNT_W'(MAX_FEATURES)) ? FI_W'(MAX_FEATURES)
                                                          : FI_W'(fcount_reg);
        fprod      = feat_reg[fidx_reg[1:0]] * weight_reg[fidx_reg[1:0]];
        last_cls   = cls_reg == ADDR_W'(CLASSES - 1);
    end

    // Side decision and saturating adds of the update.
    always_comb
    begin
        went    = proj_reg > threshold_reg;
        bin_sel = went ? bin_true : bin_false;
        bin_sum = {1'b0, bin_sel} + {(TOT_W + 1 - SW_W)'(0), sw_reg};
        tot_sum = {1'b0, (went ? ttot_reg : ftot_reg)}
                  + {(TOT_W + 1 - SW_W)'(0), sw_reg};
        bin_new = bin_sum[TOT_W] ? {TOT_W{1'b1}} : bin_sum[TOT_W-1:0];
        tot_new = tot_sum[TOT_W] ? {TOT_W{1'b1}} : tot_sum[TOT_W-1:0];
        hwr_data = bin_new;
    end

    // Count and total of the current entropy term.
    always_comb
    begin
        n_all = {1'b0, ttot_reg} + {1'b0, ftot_reg};
        case (term_reg)
            TK_PRIOR:
            begin
                cnt_sel = {1'b0, bin_true} + {1'b0, bin_false};
                tot_sel = n_all;
            end
            TK_TRUE:
            begin
                cnt_sel = {1'b0, bin_true};
                tot_sel = {1'b0, ttot_reg};
            end
            default:
            begin
                cnt_sel = {1'b0, bin_false};
                tot_sel = {1'b0, ftot_reg};
            end
        endcase
    end

    // Leading one, fraction index and length of -log2(p).
    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < P_W; i++)
        begin
            if (p_reg[i])
            begin
                lead = 5'(i);
            end
        end
        kshift   = {p_reg, 6'b0} >> lead;
        kidx     = kshift[5:0];
        len_calc = {(5'd16 - lead), 12'd0} - {5'd0, LOG_FRAC[kidx]};
        plen     = p_reg * len_reg;
        p_clamp  = (div_quot > QUO_W'(65536)) ? P_W'(65536) : div_quot[P_W-1:0];
        gain_diff = {1'b0, prior_reg} - {1'b0, sum_reg[ENT_W-1:0]};
    end

    // Side products of the weighted posterior, at full width.
    always_comb
    begin
        prod_true  = ttot_reg * ht_reg;
        prod_false = ftot_reg * hf_reg;
    end

    // Histogram and divider control.
    always_comb
    begin
        hctrl     = '0;
        hrd_addr  = cls_reg;
        div_start = 1'b0;
        div_num   = {{(NUM_W - DEN_W - 16){1'b0}}, cnt_sel, 16'd0};
        div_den   = tot_sel;
        case (state_reg)
            S_IDLE:
            begin
                hctrl.rd_en = in_valid;
                hrd_addr    = label_in_wide[ADDR_W-1:0];
                hctrl.clear = in_valid && (operation == OP_CLEAR);
            end
            S_UPD:
            begin
                hctrl.wr_en   = label_ok;
                hctrl.wr_true = went;
            end
            S_SRD:
            begin
                hctrl.rd_en = 1'b1;
            end
            S_TERM:
            begin
                div_start = (cnt_sel != '0) && (tot_sel != '0);
            end
            S_PDIVS:
            begin
                div_start = 1'b1;
                div_num   = sum_reg;
                div_den   = n_all;
            end
            default:
            begin
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            fcount_reg    <= FCNT_W'(1);
            for (int i = 0; i < 4; i++)
            begin
                weight_reg[i] <= WGT_W'(256);
            end
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_THRESHOLD:     threshold_reg <= cfg_data;
                CFG_FEATURE_COUNT: fcount_reg    <= cfg_data[FCNT_W-1:0];
                CFG_WEIGHT_ZERO:   weight_reg[0] <= cfg_data[WGT_W-1:0];
                CFG_WEIGHT_ONE:    weight_reg[1] <= cfg_data[WGT_W-1:0];
                CFG_WEIGHT_TWO:    weight_reg[2] <= cfg_data[WGT_W-1:0];
                CFG_WEIGHT_THREE:  weight_reg[3] <= cfg_data[WGT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            term_reg      <= TK_PRIOR;
            ttot_reg      <= '0;
            ftot_reg      <= '0;
            out_valid_reg <= 1'b0;
            fidx_reg      <= '0;
            cls_reg       <= '0;
        end
        else
        begin
            // Result register is filled from S_OUT and freed when taken.
            if ((state_reg == S_OUT) && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        feat_reg[0]  <= feature_a;
                        feat_reg[1]  <= feature_b;
                        feat_reg[2]  <= feature_c;
                        feat_reg[3]  <= feature_d;
                        label_reg    <= class_label;
                        sw_reg       <= sample_weight;
                        proj_reg     <= '0;
                        fidx_reg     <= '0;
                        cls_reg      <= '0;
                        term_reg     <= TK_PRIOR;
                        prior_reg    <= '0;
                        ht_reg       <= '0;
                        hf_reg       <= '0;
                        res_went_reg <= 1'b0;
                        res_gain_reg <= '0;
                        case (operation)
                            OP_CLEAR:
                            begin
                                ttot_reg  <= '0;
                                ftot_reg  <= '0;
                                state_reg <= S_OUT;
                            end
                            OP_UPDATE:
                            begin
                                state_reg <= S_PROJ;
                            end
                            OP_SCORE:
                            begin
                                state_reg <= (n_all == '0) ? S_OUT : S_SRD;
                            end
                            default:
                            begin
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                // One feature product per cycle into the projection.
                S_PROJ:
                begin
                    if (fidx_reg < used)
                    begin
                        proj_reg <= proj_reg + THR_W'(fprod);
                        fidx_reg <= fidx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_UPD;
                    end
                end
                // Bin write-back happens through the store control.
                S_UPD:
                begin
                    res_went_reg <= went;
                    if (label_ok)
                    begin
                        if (went)
                        begin
                            ttot_reg <= tot_new;
                        end
                        else
                        begin
                            ftot_reg <= tot_new;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_SRD:
                begin
                    term_reg  <= TK_PRIOR;
                    state_reg <= S_TERM;
                end
                S_TERM:
                begin
                    if ((cnt_sel != '0) && (tot_sel != '0))
                    begin
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        term_val_reg <= '0;
                        state_reg    <= S_ACC;
                    end
                end
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        p_reg     <= p_clamp;
                        state_reg <= S_LOG;
                    end
                end
                S_LOG:
                begin
                    len_reg   <= len_calc;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    term_val_reg <= ENT_W'(plen[P_W+LEN_W-1:16]);
                    state_reg    <= S_ACC;
                end
                S_ACC:
                begin
                    case (term_reg)
                        TK_PRIOR:
                        begin
                            prior_reg <= prior_reg + term_val_reg;
                            term_reg  <= TK_TRUE;
                            state_reg <= S_TERM;
                        end
                        TK_TRUE:
                        begin
                            ht_reg    <= ht_reg + term_val_reg;
                            term_reg  <= TK_FALSE;
                            state_reg <= S_TERM;
                        end
                        default:
                        begin
                            hf_reg <= hf_reg + term_val_reg;
                            if (last_cls)
                            begin
                                state_reg <= S_POST1;
                            end
                            else
                            begin
                                cls_reg   <= cls_reg + 1'b1;
                                state_reg <= S_SRD;
                            end
                        end
                    endcase
                end
                // Weighted posterior: two products, then one division.
                S_POST1:
                begin
                    prod_reg  <= NUM_W'(prod_true);
                    state_reg <= S_POST2;
                end
                S_POST2:
                begin
                    sum_reg   <= prod_reg + NUM_W'(prod_false);
                    state_reg <= S_PDIVS;
                end
                S_PDIVS:
                begin
                    state_reg <= S_PDIV;
                end
                S_PDIV:
                begin
                    if (!div_busy)
                    begin
                        sum_reg   <= NUM_W'(div_quot);
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    if (prior_reg <= sum_reg[ENT_W-1:0])
                    begin
                        res_gain_reg <= '0;
                    end
                    else if (gain_diff > (ENT_W + 1)'(65535))
                    begin
                        res_gain_reg <= {GAIN_W{1'b1}};
                    end
                    else
                    begin
                        res_gain_reg <= gain_diff[GAIN_W-1:0];
                    end
                    state_reg <= S_OUT;
                end
                // Hand the result to the output register once it is free.
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        went_reg      <= res_went_reg;
                        gain_reg      <= res_gain_reg;
                        otrue_reg     <= ttot_reg;
                        ofalse_reg    <= ftot_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready           = state_reg == S_IDLE;
    assign out_valid          = out_valid_reg;
    assign went_true          = went_reg;
    assign gain               = gain_reg;
    assign true_weight_total  = otrue_reg;
    assign false_weight_total = ofalse_reg;

endmodule
`default_nettype wire
